### design/scsp_pkg.sv
`timescale 1ns / 1ps
// scsp_pkg: event codes, opcode constants and the operand length table
// of the sound command stream parser. No dependencies.
package scsp_pkg;

	localparam logic [2:0] EV_WRITE = 3'd0;
	localparam logic [2:0] EV_WAIT  = 3'd1;
	localparam logic [2:0] EV_BLOCK = 3'd2;
	localparam logic [2:0] EV_SEEK  = 3'd3;
	localparam logic [2:0] EV_END   = 3'd4;
	localparam logic [2:0] EV_ERROR = 3'd5;

	localparam logic [7:0] OP_WAIT_N   = 8'h61;
	localparam logic [7:0] OP_WAIT_60  = 8'h62;
	localparam logic [7:0] OP_WAIT_50  = 8'h63;
	localparam logic [7:0] OP_EOD      = 8'h66;
	localparam logic [7:0] OP_BLOCK    = 8'h67;
	localparam logic [7:0] OP_PSG      = 8'hA0;
	localparam logic [7:0] OP_APU      = 8'hB4;
	localparam logic [7:0] OP_WAIT_SH  = 8'h70;
	localparam logic [7:0] OP_WAIT_MSK = 8'h0F;

	localparam logic [16:0] WAIT_60 = 17'd735;
	localparam logic [16:0] WAIT_50 = 17'd882;

	localparam logic REG_LOOP_OFFSET = 1'b0;
	localparam logic REG_LOOP_COUNT  = 1'b1;

	typedef struct packed {
		logic       known;
		logic [3:0] len;
	} op_len_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        chip;
		logic [7:0]  addr;
		logic [7:0]  value;
		logic [16:0] wcnt;
		logic [31:0] seek;
		logic        last;
	} event_t;

	function automatic op_len_t op_len(input logic [7:0] op);
		op_len_t r;
		r.known = 1'b1;
		r.len   = 4'd0;
		if (op < 8'h30) begin
			r.known = 1'b0;
		end else if (op <= 8'h3F) begin
			r.len = 4'd1;
		end else if (op <= 8'h4E) begin
			r.len = 4'd2;
		end else if (op <= 8'h50) begin
			r.len = 4'd1;
		end else if (op <= 8'h5F) begin
			r.len = 4'd2;
		end else if (op >= 8'h70 && op <= 8'h8F) begin
			r.len = 4'd0;
		end else if (op >= 8'hA0 && op <= 8'hBF) begin
			r.len = 4'd2;
		end else if (op >= 8'hC0 && op <= 8'hDF) begin
			r.len = 4'd3;
		end else if (op >= 8'hE0) begin
			r.len = 4'd4;
		end else begin
			case (op)
				8'h61: r.len = 4'd2;
				8'h62, 8'h63, 8'h66: r.len = 4'd0;
				8'h67: r.len = 4'd6;
				8'h68: r.len = 4'd11;
				8'h90, 8'h91, 8'h95: r.len = 4'd4;
				8'h92: r.len = 4'd5;
				8'h93: r.len = 4'd10;
				8'h94: r.len = 4'd1;
				default: r.known = 1'b0;
			endcase
		end
		return r;
	endfunction

endpackage

### design/sound_command_stream_parser.sv
`timescale 1ns / 1ps
// sound_command_stream_parser: byte-wise command decoder with loop control,
// an output register and a one-beat skid stage. Depends on scsp_pkg.
//
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  data_byte
// out      out  out_valid/out_stall event_kind .. block_last
// cfg      in   APB psel/penable   paddr, pwdata, prdata
//
// One byte per cycle while in_stall is low; each beat is decoded in the cycle it is accepted and its
// event, if any, is registered in the output register, or in the skid stage if the output is stalled.
// in_stall rises only when the output register and the skid stage are both full.
// Reset clears the parser state and sets loop_count to 1; loops_q reloads from loop_count.
// After an end or error event all bytes are accepted and dropped until reset.
module sound_command_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic        target_chip,
	output logic [7:0]  reg_address,
	output logic [7:0]  reg_value,
	output logic [16:0] wait_count,
	output logic [31:0] seek_target,
	output logic        block_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import scsp_pkg::*;

	logic [31:0] loop_offset_q;
	logic [7:0]  loop_count_q;
	logic [7:0]  opcode_q;
	logic [3:0]  len_q;
	logic [3:0]  idx_q;
	logic [7:0]  op0_q;
	logic [31:0] pl_q;
	logic [7:0]  loops_q;
	logic        halted_q;

	logic [7:0]  opcode_d;
	logic [3:0]  len_d;
	logic [3:0]  idx_d;
	logic [7:0]  op0_d;
	logic [31:0] pl_d;
	logic [7:0]  loops_d;
	logic        halted_d;

	event_t      ev_d, ev_o_q, ev_s_q;
	logic        ev_v;
	logic        o_valid_q, s_valid_q;
	logic        acc, take, cfg_wr;
	op_len_t     ol;
	logic        fin_en;
	logic [7:0]  fin_op, fin_last;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_LOOP_COUNT) ? {24'd0, loop_count_q} : loop_offset_q;

	assign acc      = in_valid && !in_stall;
	assign in_stall = s_valid_q;
	assign take     = o_valid_q && !out_stall;
	assign ol       = op_len(data_byte);

	always_comb begin
		opcode_d = opcode_q;
		len_d    = len_q;
		idx_d    = idx_q;
		op0_d    = op0_q;
		pl_d     = pl_q;
		loops_d  = loops_q;
		halted_d = halted_q;
		ev_d     = '0;
		ev_v     = 1'b0;
		fin_en   = 1'b0;
		fin_op   = opcode_q;
		fin_last = data_byte;
		if (acc && !halted_q) begin
			if (idx_q == 4'd0 && pl_q != 32'd0) begin
				pl_d       = pl_q - 32'd1;
				ev_v       = 1'b1;
				ev_d.kind  = EV_BLOCK;
				ev_d.value = data_byte;
				ev_d.last  = (pl_q == 32'd1);
			end else if (idx_q == 4'd0) begin
				if (!ol.known) begin
					ev_v      = 1'b1;
					ev_d.kind = EV_ERROR;
					halted_d  = 1'b1;
				end else begin
					opcode_d = data_byte;
					len_d    = ol.len;
					if (ol.len == 4'd0) begin
						fin_en = 1'b1;
						fin_op = data_byte;
					end else begin
						idx_d = 4'd1;
					end
				end
			end else begin
				if (idx_q == 4'd1)
					op0_d = data_byte;
				if (opcode_q == OP_BLOCK) begin
					case (idx_q)
						4'd3: pl_d = pl_q | {24'd0, data_byte};
						4'd4: pl_d = pl_q | {16'd0, data_byte, 8'd0};
						4'd5: pl_d = pl_q | {8'd0, data_byte, 16'd0};
						4'd6: pl_d = pl_q | {data_byte, 24'd0};
						default: pl_d = pl_q;
					endcase
				end
				if (idx_q >= len_q) begin
					idx_d  = 4'd0;
					fin_en = 1'b1;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
		end
		if (fin_en) begin
			if (fin_op == OP_PSG || fin_op == OP_APU) begin
				ev_v       = 1'b1;
				ev_d.kind  = EV_WRITE;
				ev_d.chip  = (fin_op == OP_APU);
				ev_d.addr  = op0_d;
				ev_d.value = fin_last;
			end else if (fin_op == OP_WAIT_N) begin
				ev_v      = 1'b1;
				ev_d.kind = EV_WAIT;
				ev_d.wcnt = {1'b0, fin_last, op0_d} + 17'd1;
			end else if (fin_op == OP_WAIT_60 || fin_op == OP_WAIT_50) begin
				ev_v      = 1'b1;
				ev_d.kind = EV_WAIT;
				ev_d.wcnt = (fin_op == OP_WAIT_60) ? WAIT_60 : WAIT_50;
			end else if ((fin_op & ~OP_WAIT_MSK) == OP_WAIT_SH) begin
				ev_v      = 1'b1;
				ev_d.kind = EV_WAIT;
				ev_d.wcnt = {13'd0, fin_op[3:0]} + 17'd1;
			end else if (fin_op == OP_EOD) begin
				ev_v = 1'b1;
				if (loop_offset_q != 32'd0 && loops_q != 8'd1) begin
					if (loops_q != 8'd0)
						loops_d = loops_q - 8'd1;
					ev_d.kind = EV_SEEK;
					ev_d.seek = loop_offset_q;
				end else begin
					ev_d.kind = EV_END;
					halted_d  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_offset_q <= 32'd0;
			loop_count_q  <= 8'd1;
			opcode_q      <= 8'd0;
			len_q         <= 4'd0;
			idx_q         <= 4'd0;
			pl_q          <= 32'd0;
			loops_q       <= 8'd1;
			halted_q      <= 1'b0;
			o_valid_q     <= 1'b0;
			s_valid_q     <= 1'b0;
		end else begin
			opcode_q <= opcode_d;
			len_q    <= len_d;
			idx_q    <= idx_d;
			pl_q     <= pl_d;
			halted_q <= halted_d;
			if (cfg_wr && paddr[2] == REG_LOOP_COUNT) begin
				loop_count_q <= pwdata[7:0];
				loops_q      <= pwdata[7:0];
			end else begin
				loops_q <= loops_d;
				if (cfg_wr)
					loop_offset_q <= pwdata;
			end
			if (s_valid_q) begin
				if (take) begin
					o_valid_q <= 1'b1;
					s_valid_q <= 1'b0;
				end
			end else if (!o_valid_q || take) begin
				o_valid_q <= ev_v;
			end else if (ev_v) begin
				s_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		op0_q <= op0_d;
		if (s_valid_q) begin
			if (take)
				ev_o_q <= ev_s_q;
		end else if (!o_valid_q || take) begin
			ev_o_q <= ev_d;
		end else if (ev_v) begin
			ev_s_q <= ev_d;
		end
	end

	assign out_valid   = o_valid_q;
	assign event_kind  = ev_o_q.kind;
	assign target_chip = ev_o_q.chip;
	assign reg_address = ev_o_q.addr;
	assign reg_value   = ev_o_q.value;
	assign wait_count  = ev_o_q.wcnt;
	assign seek_target = ev_o_q.seek;
	assign block_last  = ev_o_q.last;

endmodule

### design/scsp_checker.sv
`timescale 1ns / 1ps
// scsp_checker: port-level assertions for sound_command_stream_parser,
// bound to the top level below. Depends on scsp_pkg.
module scsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  event_kind,
	input logic [16:0] wait_count,
	input logic        block_last
);
	import scsp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out beat dropped while stalled");

	a_kind_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(event_kind))
		else $error("stalled event kind changed");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (event_kind == EV_END || event_kind == EV_ERROR)
		|=> !out_valid)
		else $error("event after end or error");

	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_kind == EV_WAIT || wait_count == 17'd0)
		&& (event_kind == EV_BLOCK || !block_last))
		else $error("foreign field not zero");

endmodule

bind sound_command_stream_parser scsp_checker u_scsp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.event_kind (event_kind),
	.wait_count (wait_count),
	.block_last (block_last)
);
